@@ rtl/flight_arming_mode_fsm_defines.svh @@
// Assertion macros shared by the flight arming mode machine RTL.
`ifndef FLIGHT_ARMING_MODE_FSM_DEFINES_SVH
`define FLIGHT_ARMING_MODE_FSM_DEFINES_SVH
`ifndef SYNTH
// Plain property checked on every clock edge outside reset
`define FAM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("flight arming mode check failed");
// Next-cycle implication checked outside reset
`define FAM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("flight arming mode check failed");
`else
`define FAM_ASSERT(label, prop)
`define FAM_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ rtl/fam_pkg.sv @@
// Package for the flight arming mode machine: codes, constants and shared types.
package fam_pkg;

   // Vehicle modes
   localparam logic [2:0] MODE_DISARMED   = 3'd0;
   localparam logic [2:0] MODE_ARMED      = 3'd1;
   localparam logic [2:0] MODE_READY      = 3'd2;
   localparam logic [2:0] MODE_TAKING_OFF = 3'd3;
   localparam logic [2:0] MODE_TESTING    = 3'd4;
   localparam logic [2:0] MODE_FLYING     = 3'd5;
   localparam logic [2:0] MODE_LANDING    = 3'd6;

   // Remote modes
   localparam logic [1:0] RC_DISARM = 2'd0;
   localparam logic [1:0] RC_FLY    = 2'd1;
   localparam logic [1:0] RC_LAND   = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_TILT_LIMIT     = 2'd0;
   localparam logic [1:0] REG_LANDED_RANGE   = 2'd1;
   localparam logic [1:0] REG_LANDING_RANGE  = 2'd2;
   localparam logic [1:0] REG_AIRBORNE_RANGE = 2'd3;

   // Register reset values
   localparam logic [10:0] TILT_LIMIT_RST     = 11'd600;
   localparam logic [15:0] LANDED_RANGE_RST   = 16'd10;
   localparam logic [15:0] LANDING_RANGE_RST  = 16'd500;
   localparam logic [15:0] AIRBORNE_RANGE_RST = 16'd100;

   // Landing confirmation counter, signed, from -1 up to LANDING_TICKS
   localparam logic signed [7:0] LANDING_TICKS = 8'sd50;
   localparam logic signed [7:0] CNT_FLOOR     = -8'sd1;

   // Stick thresholds in degrees
   localparam logic signed [7:0] STICK_LOW   = -8'sd90;
   localparam logic signed [7:0] STICK_HIGH  = 8'sd90;
   localparam logic signed [7:0] THROTTLE_GO = 8'sd5;

   typedef struct packed {
      logic [10:0] tilt_limit;
      logic [15:0] landed_range;
      logic [15:0] landing_allowed_range;
      logic [15:0] airborne_range;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         rc_mode;
      logic signed [7:0]  stick_yaw;
      logic signed [7:0]  stick_alt;
      logic signed [7:0]  stick_roll;
      logic signed [7:0]  stick_pitch;
      logic [15:0]        range_mm;
      logic signed [11:0] tilt_roll;
      logic signed [11:0] tilt_pitch;
      logic               gyro_ok;
      logic               accel_ok;
      logic               optflow_ok;
      logic               range_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]        vehicle_mode;
      logic [1:0]        last_rc_mode;
      logic signed [7:0] landing_ticks_left;
   } state_type;

endpackage

@@ rtl/fam_csr.sv @@
// Configuration register file on the APB-style port.
module fam_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output fam_pkg::cfg_type     cfg
);

   fam_pkg::cfg_type cfg_ff;
   fam_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Write decode on the word index
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            fam_pkg::REG_TILT_LIMIT:     cfg_in.tilt_limit = csr_pwdata[10:0];
            fam_pkg::REG_LANDED_RANGE:   cfg_in.landed_range = csr_pwdata[15:0];
            fam_pkg::REG_LANDING_RANGE:  cfg_in.landing_allowed_range = csr_pwdata[15:0];
            fam_pkg::REG_AIRBORNE_RANGE: cfg_in.airborne_range = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tilt_limit            <= fam_pkg::TILT_LIMIT_RST;
         cfg_ff.landed_range          <= fam_pkg::LANDED_RANGE_RST;
         cfg_ff.landing_allowed_range <= fam_pkg::LANDING_RANGE_RST;
         cfg_ff.airborne_range        <= fam_pkg::AIRBORNE_RANGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (csr_paddr[3:2])
         fam_pkg::REG_TILT_LIMIT:     csr_prdata = {21'd0, cfg_ff.tilt_limit};
         fam_pkg::REG_LANDED_RANGE:   csr_prdata = {16'd0, cfg_ff.landed_range};
         fam_pkg::REG_LANDING_RANGE:  csr_prdata = {16'd0, cfg_ff.landing_allowed_range};
         fam_pkg::REG_AIRBORNE_RANGE: csr_prdata = {16'd0, cfg_ff.airborne_range};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/fam_step.sv @@
// One control tick of the mode machine: the chained checks as combinational logic.
module fam_step (
   input  fam_pkg::req_type   req,
   input  fam_pkg::state_type cur,
   input  fam_pkg::cfg_type   cfg,
   output fam_pkg::state_type nxt,
   output logic               changed
);

   logic [2:0]        m;
   logic signed [7:0] cnt;
   logic [11:0]       mag_roll;
   logic [11:0]       mag_pitch;
   logic              all_ok;
   logic              on_ground;
   logic              tilt_bad;

   // Magnitudes fit 12 bits unsigned, including the most negative code
   assign mag_roll  = req.tilt_roll[11] ? (~req.tilt_roll + 12'd1) : req.tilt_roll;
   assign mag_pitch = req.tilt_pitch[11] ? (~req.tilt_pitch + 12'd1) : req.tilt_pitch;
   assign tilt_bad  = (mag_roll > {1'b0, cfg.tilt_limit}) ||
                      (mag_pitch > {1'b0, cfg.tilt_limit});
   assign all_ok    = req.gyro_ok && req.accel_ok && req.optflow_ok && req.range_ok;
   assign on_ground = req.range_mm < cfg.landed_range;

   // Checks in order; each sees the mode left by the one before
   always_comb begin
      m   = cur.vehicle_mode;
      cnt = cur.landing_ticks_left;

      if (req.rc_mode == fam_pkg::RC_DISARM) begin
         m = fam_pkg::MODE_DISARMED;
      end

      if (req.rc_mode == fam_pkg::RC_FLY && cur.last_rc_mode == fam_pkg::RC_DISARM &&
          all_ok) begin
         m = fam_pkg::MODE_ARMED;
      end

      // Arming gesture on the sticks
      if (m == fam_pkg::MODE_ARMED && req.stick_yaw <= fam_pkg::STICK_LOW &&
          req.stick_alt <= fam_pkg::STICK_LOW && req.stick_roll >= fam_pkg::STICK_HIGH &&
          req.stick_pitch <= fam_pkg::STICK_LOW) begin
         m = fam_pkg::MODE_READY;
      end

      if (m == fam_pkg::MODE_READY && req.stick_alt > fam_pkg::THROTTLE_GO) begin
         m = (req.rc_mode == fam_pkg::RC_FLY) ? fam_pkg::MODE_TAKING_OFF
                                              : fam_pkg::MODE_TESTING;
      end

      if (m == fam_pkg::MODE_TAKING_OFF && req.range_mm > cfg.airborne_range) begin
         m = fam_pkg::MODE_FLYING;
      end

      // Flying: touchdown disarm, then a landing request that can override it
      if (m == fam_pkg::MODE_FLYING) begin
         if (on_ground && req.stick_alt == fam_pkg::STICK_LOW) begin
            m = fam_pkg::MODE_DISARMED;
         end
         if (req.rc_mode == fam_pkg::RC_LAND && cur.last_rc_mode != fam_pkg::RC_LAND &&
             req.range_mm > cfg.landing_allowed_range) begin
            m = fam_pkg::MODE_LANDING;
         end
      end

      if ((m == fam_pkg::MODE_TAKING_OFF || m == fam_pkg::MODE_FLYING) && tilt_bad) begin
         m = fam_pkg::MODE_DISARMED;
      end

      // Landing: counter confirms touchdown, leaving land mode returns to flying
      if (m == fam_pkg::MODE_LANDING) begin
         if (on_ground) begin
            if (cnt < 8'sd1) begin
               m = fam_pkg::MODE_DISARMED;
            end
            if (cnt > fam_pkg::CNT_FLOOR) begin
               cnt = cnt - 8'sd1;
            end
         end else begin
            cnt = fam_pkg::LANDING_TICKS;
         end
         if (req.rc_mode != fam_pkg::RC_LAND) begin
            m = fam_pkg::MODE_FLYING;
         end
      end

      nxt.vehicle_mode       = m;
      nxt.last_rc_mode       = req.rc_mode;
      nxt.landing_ticks_left = cnt;
   end

   assign changed = (nxt.vehicle_mode != cur.vehicle_mode);

endmodule

@@ rtl/flight_arming_mode_fsm.sv @@
// Top level of the flight arming mode machine: input register, state and result register.
//
// Usage: one request word per control tick on the req_ channel carries the
// remote mode, sticks, range, tilts and sensor flags. The block answers each
// word with exactly one rsp_ word: the vehicle mode after the tick and a flag
// set when the mode changed. The csr_ port (APB-style, pready always high)
// holds the tilt limit and three range thresholds at byte addresses 0, 4, 8, 12;
// write it only while no request word is in flight.
// Order: a word accepted is captured in the input register, and its result
// is loaded into the result register when that register can take it, which
// raises rsp_valid. Throughput: one word per cycle while no result is stalled;
// the mode step is one combinational pass from the input register and the mode
// state into the result register.
// Stall: while rsp_stall holds a result, one more word is taken into the input
// register; req_stall then rises until the result register frees up.
// Reset: mode disarmed, last remote mode zero, landing counter at its full
// count, registers at their default values, both channels empty.
`include "flight_arming_mode_fsm_defines.svh"

module flight_arming_mode_fsm (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_rc_mode,
   input  logic signed [7:0]  req_stick_yaw,
   input  logic signed [7:0]  req_stick_alt,
   input  logic signed [7:0]  req_stick_roll,
   input  logic signed [7:0]  req_stick_pitch,
   input  logic [15:0]        req_range_mm,
   input  logic signed [11:0] req_tilt_roll,
   input  logic signed [11:0] req_tilt_pitch,
   input  logic               req_gyro_ok,
   input  logic               req_accel_ok,
   input  logic               req_optflow_ok,
   input  logic               req_range_ok,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_mode_now,
   output logic               rsp_mode_changed,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   fam_pkg::cfg_type   cfg;
   fam_pkg::req_type   req_word;
   fam_pkg::req_type   s1_ff;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   fam_pkg::state_type state_ff;
   fam_pkg::state_type state_in;
   logic               step_changed;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [2:0]         mode_out_ff;
   logic               changed_out_ff;
   logic               out_load;
   logic               advance;
   logic               accept;

   fam_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pack the request fields
   assign req_word.rc_mode     = req_rc_mode;
   assign req_word.stick_yaw   = req_stick_yaw;
   assign req_word.stick_alt   = req_stick_alt;
   assign req_word.stick_roll  = req_stick_roll;
   assign req_word.stick_pitch = req_stick_pitch;
   assign req_word.range_mm    = req_range_mm;
   assign req_word.tilt_roll   = req_tilt_roll;
   assign req_word.tilt_pitch  = req_tilt_pitch;
   assign req_word.gyro_ok     = req_gyro_ok;
   assign req_word.accel_ok    = req_accel_ok;
   assign req_word.optflow_ok  = req_optflow_ok;
   assign req_word.range_ok    = req_range_ok;

   // Flow control
   assign out_load     = !rsp_valid_ff || !rsp_stall;
   assign advance      = s1_valid_ff && out_load;
   assign req_stall    = s1_valid_ff && !out_load;
   assign accept       = req_valid && !req_stall;
   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;

   fam_step u_step (
      .req     (s1_ff),
      .cur     (state_ff),
      .cfg     (cfg),
      .nxt     (state_in),
      .changed (step_changed)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_ff <= req_word;
      end
   end

   // Mode state, updated as each word moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.vehicle_mode       <= fam_pkg::MODE_DISARMED;
         state_ff.last_rc_mode       <= fam_pkg::RC_DISARM;
         state_ff.landing_ticks_left <= fam_pkg::LANDING_TICKS;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         mode_out_ff    <= state_in.vehicle_mode;
         changed_out_ff <= step_changed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode_now     = mode_out_ff;
   assign rsp_mode_changed = changed_out_ff;

   // Checks
   `FAM_ASSERT_NEXT(a_out_tracks_state, advance, rsp_mode_now == state_ff.vehicle_mode)
   `FAM_ASSERT_NEXT(a_state_holds_idle, !advance, $stable(state_ff))
   `FAM_ASSERT(a_stall_only_full, !req_stall || (s1_valid_ff && rsp_valid_ff && rsp_stall))
   `FAM_ASSERT(a_cnt_bounds, (state_ff.landing_ticks_left >= fam_pkg::CNT_FLOOR) && (state_ff.landing_ticks_left <= fam_pkg::LANDING_TICKS))

endmodule
